// ===== rtl/core/risort_pkg.sv =====
// Package for the record insertion sorter.
// Holds depth, field widths and the record and control structs shared by
// the interfaces, the sort cell and the top level. No dependencies.
package risort_pkg;

  localparam int MAX_RECORDS = 8;
  localparam int CNT_W       = $clog2(MAX_RECORDS);
  localparam int KEY_W       = 16;
  localparam int SID_W       = 16;
  localparam int GRD_W       = 16;
  localparam int IDX_W       = 3;

  // One stored record with its occupancy flag
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [SID_W-1:0] sid;
    logic [GRD_W-1:0] grd;
    logic [IDX_W-1:0] idx;
  } rec_t;

  // Chain-wide control: insert a new record, or shift toward the head
  typedef struct packed {
    logic ins;
    logic shift;
  } ctrl_t;

endpackage

// ===== rtl/core/risort_if.sv =====
// Valid/ready channel interfaces for the record insertion sorter.
// Depends on risort_pkg for field widths.
interface risort_in_if;
  logic                        valid;
  logic                        ready;
  logic [risort_pkg::KEY_W-1:0] sort_key;
  logic [risort_pkg::SID_W-1:0] school_id;
  logic [risort_pkg::GRD_W-1:0] graduates;
  logic                        last_record;

  modport source (output valid, sort_key, school_id, graduates, last_record,
                  input ready);
  modport sink   (input valid, sort_key, school_id, graduates, last_record,
                  output ready);
endinterface

interface risort_out_if;
  logic                        valid;
  logic                        ready;
  logic [risort_pkg::IDX_W-1:0] original_index;
  logic [risort_pkg::KEY_W-1:0] out_key;
  logic [risort_pkg::SID_W-1:0] out_school_id;
  logic [risort_pkg::GRD_W-1:0] out_graduates;
  logic                        final_result;

  modport source (output valid, original_index, out_key, out_school_id,
                  out_graduates, final_result, input ready);
  modport sink   (input valid, original_index, out_key, out_school_id,
                  out_graduates, final_result, output ready);
endinterface

// ===== rtl/core/record_index_insertion_sort_top.sv =====
// Top level of the record insertion sorter: a chain of risort_cell slots,
// the fill counter and the drain control. Depends on risort_pkg, risort_if.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  rec_in   | in  | sort_key, school_id, graduates, last_record
//  rec_out  | out | original_index, out_key, out_school_id, out_graduates,
//           |     | final_result
//
// When a record is inserted, every cell compares in parallel and the
// chain shifts by one slot below the insertion point.
// Closing a set (last flag or full chain) starts a drain: one result per
// cycle from the head cell while rec_out is ready; rec_in is held off
// meanwhile. A stall on rec_out freezes the chain. Reset clears occupancy,
// fill count and drain state; no clearing pass is needed.
module record_index_insertion_sort_top (
  input logic          clk,
  input logic          rst,
  risort_in_if.sink    rec_in,
  risort_out_if.source rec_out
);
  import risort_pkg::*;

  rec_t                   cells     [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] takes;
  logic [MAX_RECORDS-1:0] vld;
  rec_t                   new_rec;
  rec_t                   empty_rec;
  ctrl_t                  ctrl;
  logic [CNT_W-1:0]       fill_count;
  logic                   drain;
  logic                   in_fire;
  logic                   out_fire;
  logic                   closes;

  // Incoming record, tagged with its arrival position
  always_comb begin
    new_rec.valid = 1'b1;
    new_rec.key   = rec_in.sort_key;
    new_rec.sid   = rec_in.school_id;
    new_rec.grd   = rec_in.graduates;
    new_rec.idx   = IDX_W'(fill_count);
    empty_rec       = new_rec;
    empty_rec.valid = 1'b0;
  end

  assign rec_in.ready = !drain;
  assign in_fire      = rec_in.valid && rec_in.ready;
  assign out_fire     = rec_out.valid && rec_out.ready;
  assign closes       = rec_in.last_record || (fill_count == CNT_W'(MAX_RECORDS - 1));
  assign ctrl.ins     = in_fire;
  assign ctrl.shift   = drain && rec_out.ready;

  // Sorting chain
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t p_rec;
    rec_t n_rec;
    logic p_take;
    if (i == 0) begin : g_head
      assign p_rec  = new_rec;
      assign p_take = 1'b0;
    end else begin : g_body
      assign p_rec  = cells[i-1];
      assign p_take = takes[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign n_rec = empty_rec;
    end else begin : g_mid
      assign n_rec = cells[i+1];
    end
    risort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_rec   (new_rec),
      .prev_rec  (p_rec),
      .prev_take (p_take),
      .next_rec  (n_rec),
      .rec       (cells[i]),
      .take      (takes[i])
    );
    assign vld[i] = cells[i].valid;
  end

  // Results come straight from the head cell
  assign rec_out.valid          = drain && cells[0].valid;
  assign rec_out.original_index = cells[0].idx;
  assign rec_out.out_key        = cells[0].key;
  assign rec_out.out_school_id  = cells[0].sid;
  assign rec_out.out_graduates  = cells[0].grd;
  assign rec_out.final_result   = !cells[1].valid;

  // Fill count and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      drain      <= 1'b0;
    end else begin
      if (in_fire) begin
        if (closes) begin
          fill_count <= '0;
          drain      <= 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (out_fire && rec_out.final_result) begin
        drain <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // No intake while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rec_in.ready && rec_out.valid))
    else $error("intake open while results pending");

  // Occupied slots form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (~vld[MAX_RECORDS-2:0] & vld[MAX_RECORDS-1:1]) == '0)
    else $error("gap in occupied slots");

  // While filling, occupancy matches the fill count
  a_count: assert property (@(posedge clk) disable iff (rst)
    !drain |-> ($countones(vld) == int'(fill_count)))
    else $error("fill count out of step with chain");

  // Last result of a set reopens intake with an empty chain
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_fire && rec_out.final_result |=> rec_in.ready && !vld[0])
    else $error("chain not empty after final result");
`endif

endmodule

// ===== rtl/core/risort_cell.sv =====
// One slot of the sorting chain: holds a record, compares it with the
// incoming one, and trades records with its neighbors. Depends on risort_pkg.
module risort_cell (
  input  logic              clk,
  input  logic              rst,
  input  risort_pkg::ctrl_t ctrl,
  input  risort_pkg::rec_t  new_rec,
  input  risort_pkg::rec_t  prev_rec,
  input  logic              prev_take,
  input  risort_pkg::rec_t  next_rec,
  output risort_pkg::rec_t  rec,
  output logic              take
);
  import risort_pkg::*;

  rec_t rec_next;

  // New record belongs here or earlier: empty slot or key not above ours
  assign take = ctrl.ins && (!rec.valid || (new_rec.key <= rec.key));

  // Upstream cell took the record: move ours down; first taker stores it
  always_comb begin
    rec_next = rec;
    if (ctrl.ins) begin
      if (prev_take) begin
        rec_next = prev_rec;
      end else if (take) begin
        rec_next = new_rec;
      end
    end else if (ctrl.shift) begin
      rec_next = next_rec;
    end
  end

  // Occupancy resets; payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec <= rec_next;
    end
  end

endmodule

// ===== test/tb_record_index_insertion_sort_top.sv =====
// Testbench for record_index_insertion_sort_top: streams record sets through
// rec_in and checks every sorted record on rec_out against a built-in predictor.
// Depends on risort_pkg, risort_if and the RTL of the top level.
module tb_record_index_insertion_sort_top;
  timeunit 1ns;
  timeprecision 1ps;

  import risort_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_PRINTS   = 60;

  // One expected sorted record
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [SID_W-1:0] sid;
    logic [GRD_W-1:0] grd;
    logic             fin;
  } sorted_rec_t;

  logic clk;
  logic rst;

  risort_in_if  in_ch();
  risort_out_if out_ch();

  record_index_insertion_sort_top u_top (
    .clk     (clk),
    .rst     (rst),
    .rec_in  (in_ch),
    .rec_out (out_ch)
  );

  // Predictor state: records held in ascending key order
  logic [KEY_W-1:0] held_key [MAX_RECORDS];
  logic [SID_W-1:0] held_sid [MAX_RECORDS];
  logic [GRD_W-1:0] held_grd [MAX_RECORDS];
  logic [IDX_W-1:0] held_idx [MAX_RECORDS];
  int               held_count;

  sorted_rec_t pending_sorted[$];

  int    mismatch_count;
  int    cycle_count;
  int    records_sent;
  bit    calm;
  bit    sender_quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Insert one record into the predictor; a closed set queues its sorted records
  task automatic predict_insert(input logic [KEY_W-1:0] key, input logic [SID_W-1:0] sid,
                                input logic [GRD_W-1:0] grd, input logic last);
    int          pos;
    sorted_rec_t rec;
    pos = 0;
    while (pos < held_count && key > held_key[pos])
      pos++;
    for (int k = held_count; k > pos; k--) begin
      held_key[k] = held_key[k-1];
      held_sid[k] = held_sid[k-1];
      held_grd[k] = held_grd[k-1];
      held_idx[k] = held_idx[k-1];
    end
    held_key[pos] = key;
    held_sid[pos] = sid;
    held_grd[pos] = grd;
    held_idx[pos] = IDX_W'(held_count);
    held_count++;
    if (last || held_count >= MAX_RECORDS) begin
      for (int k = 0; k < held_count; k++) begin
        rec.idx = held_idx[k];
        rec.key = held_key[k];
        rec.sid = held_sid[k];
        rec.grd = held_grd[k];
        rec.fin = (k == held_count - 1);
        pending_sorted.push_back(rec);
      end
      held_count = 0;
    end
  endtask

  // Sender gap: random burst unless the current stretch is quiet or the run is calm
  task automatic maybe_pause();
    if (!calm && !sender_quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drive one record and hold it until the transaction completes
  task automatic send_record(input logic [KEY_W-1:0] key, input logic [SID_W-1:0] sid,
                             input logic [GRD_W-1:0] grd, input logic last);
    in_ch.valid       <= 1'b1;
    in_ch.sort_key    <= key;
    in_ch.school_id   <= sid;
    in_ch.graduates   <= grd;
    in_ch.last_record <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_insert(key, sid, grd, last);
    records_sent++;
    maybe_pause();
  endtask

  // One set of n records with random content; narrow sets draw keys from 0 to 3
  task automatic send_random_set(input int n_rec);
    bit               narrow;
    bit               last;
    logic [KEY_W-1:0] key;
    narrow       = ($urandom_range(0, 2) == 0);
    sender_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_rec; i++) begin
      key = narrow ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
      if (i == n_rec - 1)
        last = (n_rec < MAX_RECORDS) ? 1'b1 : 1'($urandom_range(0, 1));
      else
        last = 1'b0;
      send_record(key, SID_W'($urandom), GRD_W'($urandom), last);
    end
  endtask

  // Receiver: stall bursts, with stretches of steady ready
  initial begin
    int stall_mode;
    out_ch.ready <= 1'b0;
    stall_mode = 1;
    forever begin
      if (!calm && stall_mode != 0 && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if ($urandom_range(0, 15) == 0)
        stall_mode = !stall_mode;
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    sorted_rec_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch("unexpected result, key", out_ch.out_key, 0);
      end else begin
        want = pending_sorted.pop_front();
        if (out_ch.original_index !== want.idx)
          report_mismatch("original_index", out_ch.original_index, want.idx);
        if (out_ch.out_key !== want.key)
          report_mismatch("out_key", out_ch.out_key, want.key);
        if (out_ch.out_school_id !== want.sid)
          report_mismatch("out_school_id", out_ch.out_school_id, want.sid);
        if (out_ch.out_graduates !== want.grd)
          report_mismatch("out_graduates", out_ch.out_graduates, want.grd);
        if (out_ch.final_result !== want.fin)
          report_mismatch("final_result", out_ch.final_result, want.fin);
      end
    end
  end

  // A lone record closed by the last flag
  task automatic test_single_record();
    send_record('0, '0, '0, 1'b1);
  endtask

  // All-ones and all-zeros fields in one set
  task automatic test_field_extremes();
    send_record('1, '1, '1, 1'b0);
    send_record('0, '1, '0, 1'b0);
    send_record('1, '0, '1, 1'b1);
  endtask

  // Equal keys: newer records land ahead of older ones
  task automatic test_equal_keys();
    for (int i = 0; i < 4; i++)
      send_record(KEY_W'(16'h1234), SID_W'(i + 1), GRD_W'(16'h00A0 + i), i == 3);
  endtask

  // Full store closes the set without the flag, then with the flag as well
  task automatic test_full_store();
    for (int i = 0; i < MAX_RECORDS; i++)
      send_record(KEY_W'(16'hF000 - i * 16'h1111), SID_W'($urandom), GRD_W'($urandom), 1'b0);
    for (int i = 0; i < MAX_RECORDS; i++)
      send_record(KEY_W'(i * 16'h0101), SID_W'($urandom), GRD_W'($urandom),
                  i == MAX_RECORDS - 1);
  endtask

  // Random sets of random sizes
  task automatic test_random_sets();
    int start;
    start = records_sent;
    while (records_sent - start < 120)
      send_random_set($urandom_range(1, MAX_RECORDS));
    sender_quiet = 1'b0;
  endtask

  // Final stretch with no idling on either side
  task automatic test_back_to_back();
    int start;
    calm  = 1'b1;
    start = records_sent;
    while (records_sent - start < 30)
      send_random_set($urandom_range(1, MAX_RECORDS));
  endtask

  // Main sequence
  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    records_sent   = 0;
    held_count     = 0;
    calm           = 1'b0;
    sender_quiet   = 1'b0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.sort_key    <= '0;
    in_ch.school_id   <= '0;
    in_ch.graduates   <= '0;
    in_ch.last_record <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_single_record();
    test_field_extremes();
    test_equal_keys();
    test_full_store();
    test_random_sets();
    test_back_to_back();

    in_ch.valid <= 1'b0;
    while (pending_sorted.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_sorted.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
